[sv/trs_pkg.sv]
// Package: shared types, constants and arithmetic helpers for the TRS matrix unit.
`timescale 1ns / 1ps
package trs_pkg;

   localparam int ANG_W      = 17;
   localparam int Q30_W      = 32;   // signed Q30 sine/cosine, |v| <= 2^30
   localparam int POLY_W     = 31;   // unsigned Q30 polynomial value, <= 2^30
   localparam int RAD_W      = 31;   // radians in Q30, <= pi/4 * 2^30
   localparam int FULL_TURN  = 46080;
   localparam int QUAR_TURN  = 11520;
   localparam int EIGH_TURN  = 5760;
   // pi * 2^32 split as PI_HI * 92160 + PI_LO
   localparam logic [17:0] PI_HI = 18'd146408;
   localparam logic [16:0] PI_LO = 17'd76425;
   localparam logic [POLY_W-1:0] Q30_ONE = 31'h4000_0000;

   // one rotation angle after reduction to an octant
   typedef struct packed {
      logic [12:0] r;      // remainder folded into [0, 5760]
      logic        swap;   // remainder lay above 45 degrees
      logic [1:0]  quad;   // quadrant 0..3
   } ang_type;

   // sine/cosine pair in signed Q30
   typedef struct packed {
      logic signed [Q30_W-1:0] s;
      logic signed [Q30_W-1:0] c;
   } sc_type;

   // divide by 2^30, round to nearest, ties away from zero
   function automatic logic signed [63:0] shr30(input logic signed [63:0] p);
      logic        neg;
      logic [63:0] mag;
      begin
         neg = p[63];
         mag = neg ? (64'd0 - 64'(p)) : 64'(p);
         mag = (mag + 64'h2000_0000) >> 30;
         shr30 = neg ? -$signed(mag) : $signed(mag);
      end
   endfunction

   // saturate to signed 32 bits
   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      begin
         if (v > 64'sh7FFF_FFFF) sat32 = 32'h7FFF_FFFF;
         else if (v < -64'sh8000_0000) sat32 = 32'h8000_0000;
         else sat32 = v[31:0];
      end
   endfunction

endpackage

[sv/trs_sincos.sv]
// Pipelined sine/cosine lane: angle reduction, radian scaling and Horner series.
`timescale 1ns / 1ps
module trs_sincos (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [trs_pkg::ANG_W-1:0] ang,
   output trs_pkg::sc_type               sc
);
   import trs_pkg::*;

   localparam int NST = 12;                    // control stages before the fixup
   localparam logic [18:0] REC45 = 19'd372828; // ceil(2^24 / 45)

   // stage 0: reduce modulo full turn and fold into an octant
   logic signed [17:0] a_m;
   logic [15:0]        a_u;
   logic [15:0]        rem;
   ang_type            red;
   always_comb begin
      a_m = 18'(ang);
      if (a_m < 0) a_m = a_m + 18'(FULL_TURN);
      if (a_m < 0) a_m = a_m + 18'(FULL_TURN);
      if (a_m >= 18'(FULL_TURN)) a_m = a_m - 18'(FULL_TURN);
      a_u = a_m[15:0];
      if (a_u >= 16'(3*QUAR_TURN)) begin
         red.quad = 2'd3; rem = a_u - 16'(3*QUAR_TURN);
      end else if (a_u >= 16'(2*QUAR_TURN)) begin
         red.quad = 2'd2; rem = a_u - 16'(2*QUAR_TURN);
      end else if (a_u >= 16'(QUAR_TURN)) begin
         red.quad = 2'd1; rem = a_u - 16'(QUAR_TURN);
      end else begin
         red.quad = 2'd0; rem = a_u;
      end
      red.swap = rem > 16'(EIGH_TURN);
      red.r    = red.swap ? 13'(16'(QUAR_TURN) - rem) : rem[12:0];
   end

   // pipeline of per-stage values
   ang_type             ctl_ff  [NST];
   logic [RAD_W-1:0]    rhi_ff;                // x * pi, whole part over 92160
   logic [28:0]         rlo_ff;                // x * pi, leftover part plus rounding
   logic [RAD_W-1:0]    t_ff    [2:NST-2];
   logic [RAD_W-1:0]    t2_ff   [3:NST-2];
   logic [POLY_W-1:0]   as4_ff, ac4_ff, as6_ff, ac6_ff;
   logic [61:0]         ps_ff, pc_ff;          // first product registers, one per series
   logic [POLY_W-1:0]   sin_ff;
   sc_type              sc_ff;

   // floor division by a small Horner constant: drop the power of two, then
   // multiply by the rounded-up reciprocal of the odd part (exact for n < 2^30)
   function automatic logic [POLY_W-1:0] divc(input logic [POLY_W-1:0] n,
                                              input logic [6:0] d);
      logic [4:0]  sh;
      logic [29:0] m;
      logic [5:0]  k;
      logic [29:0] ns;
      logic [59:0] p;
      begin
         unique case (d)
            7'd72:   begin sh = 5'd3; m = 30'd954437177; k = 6'd33; end
            7'd90:   begin sh = 5'd1; m = 30'd763549742; k = 6'd35; end
            7'd42:   begin sh = 5'd1; m = 30'd818089009; k = 6'd34; end
            7'd56:   begin sh = 5'd3; m = 30'd613566757; k = 6'd32; end
            7'd20:   begin sh = 5'd2; m = 30'd858993460; k = 6'd32; end
            7'd30:   begin sh = 5'd1; m = 30'd572662307; k = 6'd33; end
            7'd6:    begin sh = 5'd1; m = 30'd715827883; k = 6'd31; end
            7'd12:   begin sh = 5'd2; m = 30'd715827883; k = 6'd31; end
            default: begin sh = 5'd1; m = 30'd1;         k = 6'd0;  end
         endcase
         ns   = 30'(n >> sh);
         p    = 60'(ns) * 60'(m);
         divc = POLY_W'(p >> k);
      end
   endfunction

   // one Horner step: ONE - floor(p / 2^30) / d
   function automatic logic [POLY_W-1:0] hstep(input logic [61:0] p,
                                               input logic [6:0] d);
      begin
         hstep = Q30_ONE - divc(POLY_W'(p >> 30), d);
      end
   endfunction

   // quadrant and octant fixup
   function automatic sc_type fix(input logic [POLY_W-1:0] sp,
                                  input logic [POLY_W-1:0] cp,
                                  input ang_type c);
      logic signed [Q30_W-1:0] s0, c0;
      sc_type o;
      begin
         s0 = c.swap ? $signed({1'b0, cp}) : $signed({1'b0, sp});
         c0 = c.swap ? $signed({1'b0, sp}) : $signed({1'b0, cp});
         unique case (c.quad)
            2'd0:    begin o.s = s0;  o.c = c0;  end
            2'd1:    begin o.s = c0;  o.c = -s0; end
            2'd2:    begin o.s = -s0; o.c = -c0; end
            default: begin o.s = -c0; o.c = s0;  end
         endcase
         fix = o;
      end
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff[0] <= red;
         for (int i = 1; i < NST; i++) ctl_ff[i] <= ctl_ff[i-1];
         // radians: only the leftover part needs dividing by 92160
         rhi_ff <= RAD_W'(31'(red.r) * 31'(PI_HI));
         rlo_ff <= 29'(red.r) * 29'(PI_LO) + 29'd46080;
         for (int i = 3; i < NST-1; i++) t_ff[i] <= t_ff[i-1];
         // 92160 = 2048 * 45
         t_ff[2] <= rhi_ff + RAD_W'((37'(rlo_ff[28:11]) * 37'(REC45)) >> 24);
         // t squared
         for (int i = 4; i < NST-1; i++) t2_ff[i] <= t2_ff[i-1];
         t2_ff[3] <= RAD_W'((64'(t_ff[2]) * 64'(t_ff[2])) >> 30);
         // first Horner term
         as4_ff <= Q30_ONE - divc(t2_ff[3], 7'd72);
         ac4_ff <= Q30_ONE - divc(t2_ff[3], 7'd90);
         // alternating multiply / divide stages
         ps_ff <= 62'(t2_ff[4]) * 62'(as4_ff);
         pc_ff <= 62'(t2_ff[4]) * 62'(ac4_ff);
         as6_ff <= hstep(ps_ff, 7'd42);
         ac6_ff <= hstep(pc_ff, 7'd56);
      end
   end

   // later Horner stages written out
   logic [61:0] ps2_ff, pc2_ff, ps3_ff, pc3_ff, pc4_ff, pst_ff;
   logic [POLY_W-1:0] as8_ff, ac8_ff, as10_ff, ac10_ff, ac12_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         ps2_ff  <= 62'(t2_ff[6]) * 62'(as6_ff);
         pc2_ff  <= 62'(t2_ff[6]) * 62'(ac6_ff);
         as8_ff  <= hstep(ps2_ff, 7'd20);
         ac8_ff  <= hstep(pc2_ff, 7'd30);
         ps3_ff  <= 62'(t2_ff[8]) * 62'(as8_ff);
         pc3_ff  <= 62'(t2_ff[8]) * 62'(ac8_ff);
         as10_ff <= hstep(ps3_ff, 7'd6);
         ac10_ff <= hstep(pc3_ff, 7'd12);
         pst_ff  <= 62'(t_ff[10]) * 62'(as10_ff);
         pc4_ff  <= 62'(t2_ff[10]) * 62'(ac10_ff);
         ac12_ff <= hstep(pc4_ff, 7'd2);
         sin_ff  <= POLY_W'(pst_ff >> 30);
         // quadrant fixup; sin_ff, ac12_ff and ctl index 11 share a stage
         sc_ff   <= fix(sin_ff, ac12_ff, ctl_ff[NST-1]);
      end
   end

   assign sc = sc_ff;
endmodule

[sv/trs_merge.sv]
// Merge stage: combines the three sine/cosine lanes into the scaled rotation rows.
`timescale 1ns / 1ps
module trs_merge (
   input  logic                  clock,
   input  logic                  en,
   input  trs_pkg::sc_type       p_sc,
   input  trs_pkg::sc_type       y_sc,
   input  trs_pkg::sc_type       r_sc,
   input  logic signed [31:0]    scale_x,
   input  logic signed [31:0]    scale_y,
   input  logic signed [31:0]    scale_z,
   output logic [31:0]           m [9]
);
   import trs_pkg::*;

   function automatic logic signed [Q30_W-1:0] qm(input logic signed [Q30_W-1:0] a,
                                                   input logic signed [Q30_W-1:0] b);
      begin
         qm = Q30_W'(shr30(64'(a) * 64'(b)));
      end
   endfunction

   // stage 1: two-factor terms
   logic signed [Q30_W-1:0] sysp_ff, cysp_ff, cycr_ff, cysr_ff, sycp_ff, cpsr_ff,
                            cpcr_ff, nsp_ff, sycr_ff, sysr_ff, cycp_ff, sr_ff, cr_ff;
   // stage 2: rotation entries
   logic signed [Q30_W-1:0] r_ff [9];
   logic signed [31:0] sx1_ff, sy1_ff, sz1_ff, sx2_ff, sy2_ff, sz2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sysp_ff <= qm(y_sc.s, p_sc.s);
         cysp_ff <= qm(y_sc.c, p_sc.s);
         cycr_ff <= qm(y_sc.c, r_sc.c);
         cysr_ff <= qm(y_sc.c, r_sc.s);
         sycp_ff <= qm(y_sc.s, p_sc.c);
         cpsr_ff <= qm(p_sc.c, r_sc.s);
         cpcr_ff <= qm(p_sc.c, r_sc.c);
         nsp_ff  <= -p_sc.s;
         sycr_ff <= qm(y_sc.s, r_sc.c);
         sysr_ff <= qm(y_sc.s, r_sc.s);
         cycp_ff <= qm(y_sc.c, p_sc.c);
         sr_ff   <= r_sc.s;
         cr_ff   <= r_sc.c;
         sx1_ff <= scale_x; sy1_ff <= scale_y; sz1_ff <= scale_z;
         // three-factor terms and sums
         r_ff[0] <= cycr_ff + qm(sysp_ff, sr_ff);
         r_ff[1] <= qm(sysp_ff, cr_ff) - cysr_ff;
         r_ff[2] <= sycp_ff;
         r_ff[3] <= cpsr_ff;
         r_ff[4] <= cpcr_ff;
         r_ff[5] <= nsp_ff;
         r_ff[6] <= qm(cysp_ff, sr_ff) - sycr_ff;
         r_ff[7] <= sysr_ff + qm(cysp_ff, cr_ff);
         r_ff[8] <= cycp_ff;
         sx2_ff <= sx1_ff; sy2_ff <= sy1_ff; sz2_ff <= sz1_ff;
         // scale and saturate
         for (int i = 0; i < 9; i++) begin
            m[i] <= sat32(shr30(64'(r_ff[i]) *
                     64'((i % 3 == 0) ? sx2_ff : (i % 3 == 1) ? sy2_ff : sz2_ff)));
         end
      end
   end
endmodule

[sv/trs_matrix_from_euler_unit.sv]
// Top level: TRS model matrix from position, Euler angles and scale.
//
// Input channel req_*: position, pitch/yaw/roll in 1/128 degree, scale (Q16.16).
// Result channel rsp_*: rows 0..2 of T*Ry*Rx*Rz*S in Q16.16, saturated.
// One transfer in, one transfer out, in order.
// Throughput: one item per cycle while the receiver does not stall. The result
// path runs through three parallel 13-stage sine/cosine lanes (multiply stages
// alternating with reciprocal-divide stages) and the 3-stage merge.
// The whole pipeline advances only when its last stage is empty or taken;
// when the receiver stalls the pipeline freezes and req_ready drops, so
// nothing is lost. The output register holds its item until taken.
// Reset clears only the valid bits; data registers are left alone.
`timescale 1ns / 1ps
module trs_matrix_from_euler_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [16:0] req_pitch_deg,
   input  logic signed [16:0] req_yaw_deg,
   input  logic signed [16:0] req_roll_deg,
   input  logic signed [31:0] req_scale_x,
   input  logic signed [31:0] req_scale_y,
   input  logic signed [31:0] req_scale_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_m00, rsp_m01, rsp_m02, rsp_m03,
   output logic signed [31:0] rsp_m10, rsp_m11, rsp_m12, rsp_m13,
   output logic signed [31:0] rsp_m20, rsp_m21, rsp_m22, rsp_m23
);
   import trs_pkg::*;

   localparam int LAT = 16;
   localparam int SCL = 13;   // stage at which lane outputs appear

   logic en;
   logic [LAT-1:0] vld_ff;
   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en;

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[LAT-2:0], req_valid};
   end

   // scale and position delay lines
   logic signed [31:0] scl_ff [SCL][3];
   logic signed [31:0] pos_ff [LAT][3];
   always_ff @(posedge clock) begin
      if (en) begin
         scl_ff[0][0] <= req_scale_x; scl_ff[0][1] <= req_scale_y;
         scl_ff[0][2] <= req_scale_z;
         pos_ff[0][0] <= req_pos_x; pos_ff[0][1] <= req_pos_y; pos_ff[0][2] <= req_pos_z;
         for (int i = 1; i < SCL; i++) scl_ff[i] <= scl_ff[i-1];
         for (int i = 1; i < LAT; i++) pos_ff[i] <= pos_ff[i-1];
      end
   end

   // three sine/cosine lanes
   sc_type p_sc, y_sc, r_sc;
   trs_sincos u_p (.clock(clock), .en(en), .ang(req_pitch_deg), .sc(p_sc));
   trs_sincos u_y (.clock(clock), .en(en), .ang(req_yaw_deg),   .sc(y_sc));
   trs_sincos u_r (.clock(clock), .en(en), .ang(req_roll_deg),  .sc(r_sc));

   logic [31:0] m [9];
   trs_merge u_mg (
      .clock(clock), .en(en), .p_sc(p_sc), .y_sc(y_sc), .r_sc(r_sc),
      .scale_x(scl_ff[SCL-1][0]), .scale_y(scl_ff[SCL-1][1]),
      .scale_z(scl_ff[SCL-1][2]), .m(m)
   );

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_m00 = m[0]; assign rsp_m01 = m[1]; assign rsp_m02 = m[2];
   assign rsp_m10 = m[3]; assign rsp_m11 = m[4]; assign rsp_m12 = m[5];
   assign rsp_m20 = m[6]; assign rsp_m21 = m[7]; assign rsp_m22 = m[8];
   assign rsp_m03 = pos_ff[LAT-1][0];
   assign rsp_m13 = pos_ff[LAT-1][1];
   assign rsp_m23 = pos_ff[LAT-1][2];
endmodule

[tb/tb_trs_matrix_from_euler_unit.sv]
// Testbench for the TRS matrix unit: random and directed items, scoreboard check.
`timescale 1ns / 1ps
module tb_trs_matrix_from_euler_unit;
   import trs_pkg::*;

   typedef struct {
      logic signed [31:0] m [12];
   } matrix_type;

   // expected-matrix store and compare
   class matrix_board;
      matrix_type pending[$];
      int errors = 0;

      function logic [63:0] rad(input logic [63:0] x);
         return (x * 64'd13493037705 + 64'd46080) / 64'd92160;
      endfunction

      function longint poly_sin(input logic [63:0] x);
         logic [63:0] t, t2, a;
         t = rad(x);
         t2 = (t * t) >> 30;
         a = 64'h4000_0000 - t2 / 72;
         a = 64'h4000_0000 - ((t2 * a) >> 30) / 42;
         a = 64'h4000_0000 - ((t2 * a) >> 30) / 20;
         a = 64'h4000_0000 - ((t2 * a) >> 30) / 6;
         return longint'((t * a) >> 30);
      endfunction

      function longint poly_cos(input logic [63:0] x);
         logic [63:0] t, t2, a;
         t = rad(x);
         t2 = (t * t) >> 30;
         a = 64'h4000_0000 - t2 / 90;
         a = 64'h4000_0000 - ((t2 * a) >> 30) / 56;
         a = 64'h4000_0000 - ((t2 * a) >> 30) / 30;
         a = 64'h4000_0000 - ((t2 * a) >> 30) / 12;
         a = 64'h4000_0000 - ((t2 * a) >> 30) / 2;
         return longint'(a);
      endfunction

      function void angle_sc(input logic signed [16:0] ang, output longint s, output longint c);
         longint a, q, r, s0, c0;
         a = ((longint'(ang) % FULL_TURN) + FULL_TURN) % FULL_TURN;
         q = a / QUAR_TURN;
         r = a % QUAR_TURN;
         if (r <= EIGH_TURN) begin
            s0 = poly_sin(r); c0 = poly_cos(r);
         end else begin
            s0 = poly_cos(QUAR_TURN - r); c0 = poly_sin(QUAR_TURN - r);
         end
         case (q)
            0: begin s = s0;  c = c0;  end
            1: begin s = c0;  c = -s0; end
            2: begin s = -s0; c = -c0; end
            default: begin s = -c0; c = s0; end
         endcase
      endfunction

      // rescale by 2^30, nearest, ties away from zero
      function longint round30(input longint p);
         longint mag;
         mag = (p < 0) ? -p : p;
         mag = (mag + (64'sd1 <<< 29)) >>> 30;
         return (p < 0) ? -mag : mag;
      endfunction

      function logic signed [31:0] clip(input longint v);
         if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
         if (v < -64'sd2147483648) return 32'h8000_0000;
         return v[31:0];
      endfunction

      function void note_request(input logic signed [31:0] pos [3],
                                 input logic signed [16:0] ang [3],
                                 input logic signed [31:0] scl [3]);
         longint sp, cp, sy, cy, sr, cr, sysp, cysp;
         longint rm [9];
         matrix_type e;
         angle_sc(ang[0], sp, cp);
         angle_sc(ang[1], sy, cy);
         angle_sc(ang[2], sr, cr);
         sysp = round30(sy * sp);
         cysp = round30(cy * sp);
         rm[0] = round30(cy * cr) + round30(sysp * sr);
         rm[1] = round30(sysp * cr) - round30(cy * sr);
         rm[2] = round30(sy * cp);
         rm[3] = round30(cp * sr);
         rm[4] = round30(cp * cr);
         rm[5] = -sp;
         rm[6] = round30(cysp * sr) - round30(sy * cr);
         rm[7] = round30(sy * sr) + round30(cysp * cr);
         rm[8] = round30(cy * cp);
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++)
               e.m[i*4+j] = clip(round30(rm[i*3+j] * longint'(scl[j])));
            e.m[i*4+3] = pos[i];
         end
         pending.push_back(e);
      endfunction

      function void check_matrix(input logic signed [31:0] got [12]);
         matrix_type e;
         if (pending.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
            return;
         end
         e = pending.pop_front();
         for (int k = 0; k < 12; k++)
            if (got[k] !== e.m[k]) begin
               $error("m%0d%0d: expected %0d actual %0d", k / 4, k % 4, e.m[k], got[k]);
               errors++;
            end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, rsp_ready = 0;
   logic req_ready, rsp_valid;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [16:0] req_pitch_deg = 0, req_yaw_deg = 0, req_roll_deg = 0;
   logic signed [31:0] req_scale_x = 0, req_scale_y = 0, req_scale_z = 0;
   logic signed [31:0] rsp_m00, rsp_m01, rsp_m02, rsp_m03;
   logic signed [31:0] rsp_m10, rsp_m11, rsp_m12, rsp_m13;
   logic signed [31:0] rsp_m20, rsp_m21, rsp_m22, rsp_m23;

   matrix_board board = new();
   int send_idle = 0, recv_stall = 0;

   always #5 clock = ~clock;

   trs_matrix_from_euler_unit u_top (.*);

   // note accepted requests, check accepted results
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         board.note_request('{req_pos_x, req_pos_y, req_pos_z},
                            '{req_pitch_deg, req_yaw_deg, req_roll_deg},
                            '{req_scale_x, req_scale_y, req_scale_z});
      if (!reset && rsp_valid && rsp_ready)
         board.check_matrix('{rsp_m00, rsp_m01, rsp_m02, rsp_m03,
                              rsp_m10, rsp_m11, rsp_m12, rsp_m13,
                              rsp_m20, rsp_m21, rsp_m22, rsp_m23});
   end

   // receiver back-pressure
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall);

   // one transfer, with random leading idle cycles
   task automatic send_item(input logic signed [31:0] px, py, pz,
                            input logic signed [16:0] ap, ay, ar,
                            input logic signed [31:0] sx, sy, sz);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_pos_x <= px; req_pos_y <= py; req_pos_z <= pz;
      req_pitch_deg <= ap; req_yaw_deg <= ay; req_roll_deg <= ar;
      req_scale_x <= sx; req_scale_y <= sy; req_scale_z <= sz;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic signed [16:0] rand_angle();
      case ($urandom_range(3))
         0: return 17'($urandom);
         1: return 17'($signed(32'($urandom_range(92160))) - 46080);
         2: return 17'(32'($urandom_range(8)) * 5760 - 23040 + 32'($urandom_range(2)) - 1);
         default: return 17'($signed(32'($urandom_range(2880))) - 1440);
      endcase
   endfunction

   function automatic logic signed [31:0] rand_scale();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed(32'($urandom_range(262144))) - 131072;
         default: return $signed(32'($urandom_range(8388608))) - 4194304;
      endcase
   endfunction

   initial begin
      logic signed [16:0] angs [10];
      logic signed [31:0] scls [6];
      angs = '{0, 5760, 11520, 17280, -11520, 46080, -46080, 65535, -65536, 5761};
      scls = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000, 0, -32'sh0001_0000, 1};
      repeat (12) @(posedge clock);
      reset <= 0;
      // directed: angle edges and scale extremes
      for (int k = 0; k < 10; k++)
         send_item(32'sh7FFF_FFFF, 32'sh8000_0000, k, angs[k], angs[(k + 3) % 10],
                   angs[(k + 7) % 10], scls[k % 6], scls[(k + 1) % 6], scls[(k + 2) % 6]);
      for (int k = 0; k < 6; k++)
         send_item(-1, 0, 1, 17'sd5760, 17'sd0, 17'sd11520, scls[k], scls[k], scls[k]);
      // random phases with different idle mixes
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 54; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 54; end
            3: begin send_idle = 6;  recv_stall = 6;  end
            default: begin send_idle = 0; recv_stall = 0; end
         endcase
         repeat (120)
            send_item($urandom, $urandom, $urandom, rand_angle(), rand_angle(),
                      rand_angle(), rand_scale(), rand_scale(), rand_scale());
      end
      req_valid <= 0;
      recv_stall = 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end
endmodule

[sim.f]
sv/trs_pkg.sv
sv/trs_sincos.sv
sv/trs_merge.sv
sv/trs_matrix_from_euler_unit.sv
tb/tb_trs_matrix_from_euler_unit.sv
